>>> hdl/irac_pkg.sv
// ----------------------------------------------------------------------------
// irac_pkg: shared types and constants of the ir a/c frame decoder
// widths, error codes, register indexes and the front to back item format
// ----------------------------------------------------------------------------
package irac_pkg;

    localparam int DUR_W         = 16;
    localparam int TOL_W         = 6;
    localparam int PROD_W        = 24;
    localparam int CODE_W        = 24;
    localparam int BYTE_W        = 8;
    localparam int ERR_W         = 3;
    localparam int ENTRY_W       = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int PCT           = 100;

    localparam int FRAME_ENTRIES = 100;
    localparam int FIRST_DATA    = 3;
    localparam int LAST_DATA     = 98;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = '1;

    // error codes, lowest number wins except bit timing over complement
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_COUNT     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_HDR_MARK  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_HDR_SPACE = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BIT       = 3'd4;
    localparam logic [ERR_W-1:0] ERR_COMPL     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_SPACE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd6;

    // what the back end does with one duration
    typedef enum logic [2:0] {
        K_REPEAT,
        K_HDR_MARK,
        K_HDR_SPACE,
        K_BIT_MARK,
        K_BIT_SPACE,
        K_SKIP
    } t_kind;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             last;
        t_kind            kind;
        logic             byte_end;
        logic [1:0]       pair_idx;
        logic             odd_byte;
        logic             count_ok;
    } t_item;

    typedef struct packed {
        logic [DUR_W-1:0] hdr_mark;
        logic [DUR_W-1:0] hdr_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] rpt_space;
        logic [TOL_W-1:0] tolerance;
    } t_cfg;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hdl/irac_front.sv
// ----------------------------------------------------------------------------
// irac_front: entry counter and classifier
// numbers the durations of a frame and tags each with its role
// ----------------------------------------------------------------------------
module irac_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [irac_pkg::DUR_W-1:0]          i_duration,
    input  logic                                i_last,
    input  irac_pkg::t_q_stat                   i_q_stat,
    output logic                                o_ready,
    output logic                                o_push,
    output irac_pkg::t_item                     o_item
);

    logic [irac_pkg::ENTRY_W-1:0] r_idx;
    logic [irac_pkg::ENTRY_W-1:0] n_idx;
    logic [irac_pkg::ENTRY_W-1:0] w_rel;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;
    assign w_rel   = r_idx - irac_pkg::ENTRY_W'(irac_pkg::FIRST_DATA);

    always_comb begin
        o_item          = '0;
        o_item.duration = i_duration;
        o_item.last     = i_last;
        o_item.byte_end = 1'b0;
        o_item.pair_idx = w_rel[6:5];
        o_item.odd_byte = w_rel[4];
        o_item.count_ok = (r_idx == irac_pkg::ENTRY_W'(irac_pkg::FRAME_ENTRIES - 1));
        if (r_idx == irac_pkg::ENTRY_W'(0)) begin
            o_item.kind = irac_pkg::K_REPEAT;
        end else if (r_idx == irac_pkg::ENTRY_W'(1)) begin
            o_item.kind = irac_pkg::K_HDR_MARK;
        end else if (r_idx == irac_pkg::ENTRY_W'(2)) begin
            o_item.kind = irac_pkg::K_HDR_SPACE;
        end else if (r_idx <= irac_pkg::ENTRY_W'(irac_pkg::LAST_DATA)) begin
            o_item.kind     = w_rel[0] ? irac_pkg::K_BIT_SPACE : irac_pkg::K_BIT_MARK;
            o_item.byte_end = (w_rel[3:0] == 4'hF);
        end else begin
            o_item.kind = irac_pkg::K_SKIP;
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (o_push) begin
            if (i_last) begin
                n_idx = '0;
            end else if (r_idx != irac_pkg::ENTRY_MAX) begin
                n_idx = r_idx + irac_pkg::ENTRY_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

>>> hdl/irac_queue.sv
// ----------------------------------------------------------------------------
// irac_queue: small first-in first-out queue between front and back
// depth must be a power of two, at least two
// ----------------------------------------------------------------------------
module irac_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  irac_pkg::t_item     i_item,
    input  logic                i_pop,
    output irac_pkg::t_item     o_item,
    output irac_pkg::t_q_stat   o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    irac_pkg::t_item     r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/irac_back.sv
// ----------------------------------------------------------------------------
// irac_back: tolerance match and frame state
// stage one forms the window products, stage two compares and updates state
// ----------------------------------------------------------------------------
module irac_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  irac_pkg::t_cfg                      i_cfg,
    input  irac_pkg::t_q_stat                   i_q_stat,
    input  irac_pkg::t_item                     i_item,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_frame_ok,
    output logic [irac_pkg::ERR_W-1:0]          o_error_code,
    output logic                                o_is_repeat,
    output logic [irac_pkg::CODE_W-1:0]         o_code_value
);

    localparam int PW = irac_pkg::PROD_W;

    // stage one
    logic                              r_s1_valid;
    irac_pkg::t_item                   r_s1_item;
    logic [PW-1:0]                     r_d100;
    logic [PW-1:0]                     r_pa;
    logic [PW-1:0]                     r_qa;
    logic [PW-1:0]                     r_pb;
    logic [PW-1:0]                     r_qb;

    logic [7:0]                        w_lo_pct;
    logic [7:0]                        w_hi_pct;
    logic [irac_pkg::DUR_W-1:0]        w_exp_a;
    logic                              w_consume;

    // frame state
    logic [irac_pkg::BYTE_W-1:0]       r_shift,  n_shift;
    logic [irac_pkg::BYTE_W-1:0]       r_true,   n_true;
    logic [irac_pkg::CODE_W-1:0]       r_acc,    n_acc;
    logic [irac_pkg::ERR_W-1:0]        r_err,    n_err;
    logic                              r_rep,    n_rep;

    // result register
    logic                              r_out_valid;
    logic                              r_frame_ok, n_frame_ok;
    logic [irac_pkg::ERR_W-1:0]        r_out_err,  n_out_err;
    logic                              r_out_rep,  n_out_rep;
    logic [irac_pkg::CODE_W-1:0]       r_out_code, n_out_code;

    logic [PW-1:0]                     w_d100_hi;
    logic                              w_match_a;
    logic                              w_match_b;
    logic                              w_bad;

    assign w_lo_pct  = 8'(irac_pkg::PCT) - 8'(i_cfg.tolerance);
    assign w_hi_pct  = 8'(irac_pkg::PCT) + 8'(i_cfg.tolerance);
    assign w_consume = r_s1_valid && (!r_s1_item.last || !r_out_valid || i_ready);
    assign o_pop     = !i_q_stat.empty && (!r_s1_valid || w_consume);

    always_comb begin
        case (i_item.kind)
            irac_pkg::K_REPEAT:    w_exp_a = i_cfg.rpt_space;
            irac_pkg::K_HDR_MARK:  w_exp_a = i_cfg.hdr_mark;
            irac_pkg::K_HDR_SPACE: w_exp_a = i_cfg.hdr_space;
            irac_pkg::K_BIT_MARK:  w_exp_a = i_cfg.bit_mark;
            irac_pkg::K_BIT_SPACE: w_exp_a = i_cfg.one_space;
            default:               w_exp_a = i_cfg.bit_mark;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (w_consume) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_item <= i_item;
            r_d100    <= PW'(i_item.duration) * PW'(irac_pkg::PCT);
            r_pa      <= PW'(w_exp_a) * PW'(w_lo_pct);
            r_qa      <= PW'(w_exp_a) * PW'(w_hi_pct);
            r_pb      <= PW'(i_cfg.zero_space) * PW'(w_lo_pct);
            r_qb      <= PW'(i_cfg.zero_space) * PW'(w_hi_pct);
        end
    end

    // floor(p/100) <= d  <=>  p <= 100*d + 99 ; d <= floor(q/100) <=> 100*d <= q
    assign w_d100_hi = r_d100 + PW'(irac_pkg::PCT - 1);
    assign w_match_a = (r_pa <= w_d100_hi) && (r_d100 <= r_qa);
    assign w_match_b = (r_pb <= w_d100_hi) && (r_d100 <= r_qb);

    always_comb begin
        n_shift    = r_shift;
        n_true     = r_true;
        n_acc      = r_acc;
        n_err      = r_err;
        n_rep      = r_rep;
        n_frame_ok = r_frame_ok;
        n_out_err  = r_out_err;
        n_out_rep  = r_out_rep;
        n_out_code = r_out_code;
        w_bad      = 1'b0;
        if (w_consume) begin
            case (r_s1_item.kind)
                irac_pkg::K_REPEAT: begin
                    n_rep = w_match_a;
                end
                irac_pkg::K_HDR_MARK: begin
                    if (!w_match_a && r_err == irac_pkg::ERR_NONE) begin
                        n_err = irac_pkg::ERR_HDR_MARK;
                    end
                end
                irac_pkg::K_HDR_SPACE: begin
                    if (!w_match_a && r_err == irac_pkg::ERR_NONE) begin
                        n_err = irac_pkg::ERR_HDR_SPACE;
                    end
                end
                irac_pkg::K_BIT_MARK: begin
                    w_bad = !w_match_a;
                end
                irac_pkg::K_BIT_SPACE: begin
                    // a one wins when both windows hold the space
                    if (w_match_a) begin
                        n_shift = {r_shift[irac_pkg::BYTE_W-2:0], 1'b1};
                    end else if (w_match_b) begin
                        n_shift = {r_shift[irac_pkg::BYTE_W-2:0], 1'b0};
                    end else begin
                        w_bad = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (w_bad && (n_err == irac_pkg::ERR_NONE || n_err == irac_pkg::ERR_COMPL)) begin
                n_err = irac_pkg::ERR_BIT;
            end
            if (r_s1_item.byte_end) begin
                if (!r_s1_item.odd_byte) begin
                    n_true = n_shift;
                end else begin
                    if ((~r_true != n_shift) && n_err == irac_pkg::ERR_NONE) begin
                        n_err = irac_pkg::ERR_COMPL;
                    end
                    n_acc = r_acc | (irac_pkg::CODE_W'(r_true)
                            << {r_s1_item.pair_idx, 3'b000});
                end
                n_shift = '0;
            end
            if (r_s1_item.last) begin
                n_out_err  = r_s1_item.count_ok ? n_err : irac_pkg::ERR_COUNT;
                n_frame_ok = (n_out_err == irac_pkg::ERR_NONE);
                n_out_rep  = n_rep;
                n_out_code = n_frame_ok ? n_acc : '0;
                n_shift    = '0;
                n_true     = '0;
                n_acc      = '0;
                n_err      = irac_pkg::ERR_NONE;
                n_rep      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_true      <= '0;
            r_acc       <= '0;
            r_err       <= irac_pkg::ERR_NONE;
            r_rep       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_shift <= n_shift;
            r_true  <= n_true;
            r_acc   <= n_acc;
            r_err   <= n_err;
            r_rep   <= n_rep;
            if (w_consume && r_s1_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame_ok <= n_frame_ok;
        r_out_err  <= n_out_err;
        r_out_rep  <= n_out_rep;
        r_out_code <= n_out_code;
    end

    assign o_valid      = r_out_valid;
    assign o_frame_ok   = r_frame_ok;
    assign o_error_code = r_out_err;
    assign o_is_repeat  = r_out_rep;
    assign o_code_value = r_out_code;

endmodule

>>> hdl/ir_ac_frame_pulse_decoder.sv
// ----------------------------------------------------------------------------
// ir_ac_frame_pulse_decoder: infrared air-conditioner frame decoder
// checks header and pulse-distance timing of one frame and returns its
// three byte/complement pairs as a 24-bit code with an error code
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ---------------------------
//  input     in         i_valid / o_ready            i_duration_us, i_frame_end
//  result    out        o_valid / i_ready            o_frame_ok, o_error_code,
//                                                    o_is_repeat, o_code_value
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
//  one duration beat is taken every cycle while the queue has room; the
//  front counts and tags, the back runs a two-stage multiply/compare pipe
//  a result beat shows once the last duration of a frame has moved from
//  the queue slot into the product register and from there loads the
//  result register
//  a stalled result holds only the last duration of the next frame in the
//  pipe; earlier durations keep flowing, later ones fill the queue behind it
//  synchronous active-low reset clears counters, queue and frame state and
//  loads the register defaults; config beats are always taken
// ----------------------------------------------------------------------------
module ir_ac_frame_pulse_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // duration beats
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [irac_pkg::DUR_W-1:0]          i_duration_us,
    input  logic                                i_frame_end,
    // result beats
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_frame_ok,
    output logic [irac_pkg::ERR_W-1:0]          o_error_code,
    output logic                                o_is_repeat,
    output logic [irac_pkg::CODE_W-1:0]         o_code_value,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [irac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [irac_pkg::DUR_W-1:0]          i_cfg_data
);

    irac_pkg::t_cfg     r_cfg;
    irac_pkg::t_item    w_push_item;
    irac_pkg::t_item    w_head_item;
    irac_pkg::t_q_stat  w_q_stat;
    logic               w_push;
    logic               w_pop;

    // register file; the user must write it only between frames, the block itself does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hdr_mark   <= irac_pkg::DUR_W'(4400);
            r_cfg.hdr_space  <= irac_pkg::DUR_W'(4400);
            r_cfg.bit_mark   <= irac_pkg::DUR_W'(560);
            r_cfg.one_space  <= irac_pkg::DUR_W'(1690);
            r_cfg.zero_space <= irac_pkg::DUR_W'(560);
            r_cfg.rpt_space  <= irac_pkg::DUR_W'(5200);
            r_cfg.tolerance  <= irac_pkg::TOL_W'(25);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                irac_pkg::CFG_HDR_MARK:   r_cfg.hdr_mark   <= i_cfg_data;
                irac_pkg::CFG_HDR_SPACE:  r_cfg.hdr_space  <= i_cfg_data;
                irac_pkg::CFG_BIT_MARK:   r_cfg.bit_mark   <= i_cfg_data;
                irac_pkg::CFG_ONE_SPACE:  r_cfg.one_space  <= i_cfg_data;
                irac_pkg::CFG_ZERO_SPACE: r_cfg.zero_space <= i_cfg_data;
                irac_pkg::CFG_RPT_SPACE:  r_cfg.rpt_space  <= i_cfg_data;
                irac_pkg::CFG_TOLERANCE:  r_cfg.tolerance  <= i_cfg_data[irac_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: entry numbering and role of each duration
    irac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_duration (i_duration_us),
        .i_last     (i_frame_end),
        .i_q_stat   (w_q_stat),
        .o_ready    (o_ready),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // decouples the front from result stalls
    irac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_stat  (w_q_stat)
    );

    // back: tolerance windows, bit assembly, error tracking, result register
    irac_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_stat     (w_q_stat),
        .i_item       (w_head_item),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_ok   (o_frame_ok),
        .o_error_code (o_error_code),
        .o_is_repeat  (o_is_repeat),
        .o_code_value (o_code_value)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ir a/c frame pulse decoder
// builds whole frames of mark/space durations, predicts the decoded code, error
// and repeat flag of every frame, and checks each result beat against it while
// both handshakes, outside the steady-flow runs, idle at random
// ----------------------------------------------------------------------------
module tb_top;
    import irac_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_WAIT     = 13;
    localparam int DUR_MAX      = (1 << DUR_W) - 1;
    localparam int PAIRS        = 3;
    localparam int BYTE_ENTRIES = 2 * BYTE_W;   // one mark and one space per bit
    localparam int ENT_LEAD     = 0;
    localparam int ENT_HDR_MARK = 1;
    localparam int ENT_HDR_SPC  = 2;
    localparam int RAND_BEATS   = 200;
    localparam logic [6:0] ALL_REGS = 7'h7F;

    localparam t_cfg RESET_CFG = '{hdr_mark: 16'd4400, hdr_space: 16'd4400,
                                   bit_mark: 16'd560, one_space: 16'd1690,
                                   zero_space: 16'd560, rpt_space: 16'd5200,
                                   tolerance: 6'd25};

    typedef struct packed {
        logic              ok;
        logic [ERR_W-1:0]  err;
        logic              rpt;
        logic [CODE_W-1:0] code;
    } t_frame_res;

    // dut ports, all inputs known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [DUR_W-1:0]     i_duration_us = '0;
    logic                 i_frame_end   = 1'b0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic                 o_frame_ok;
    logic [ERR_W-1:0]     o_error_code;
    logic                 o_is_repeat;
    logic [CODE_W-1:0]    o_code_value;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [DUR_W-1:0]     i_cfg_data    = '0;

    // decoder copy: register settings and the state of the frame in flight
    t_cfg               cfg_m = RESET_CFG;
    logic [ENTRY_W-1:0] ent_idx;
    logic [BYTE_W-1:0]  bits_in;
    logic [BYTE_W-1:0]  held_byte;
    logic [CODE_W-1:0]  code_acc;
    logic [ERR_W-1:0]   err_first;
    logic               rpt_flag;

    t_frame_res       frame_results_due[$];
    logic [DUR_W-1:0] frame_q[$];

    bit steady_flow    = 1'b0;   // no idling on either side while set
    int rx_hold        = 0;
    int fault_count    = 0;
    int beats_sent     = 0;
    int frames_sent    = 0;
    int results_checked = 0;
    int clean_seen     = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    ir_ac_frame_pulse_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_duration_us (i_duration_us),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_frame_ok    (o_frame_ok),
        .o_error_code  (o_error_code),
        .o_is_repeat   (o_is_repeat),
        .o_code_value  (o_code_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // timing windows and the frame decoder copy
    // ------------------------------------------------------------------------

    // window bounds are floor(e*(100-t)/100) and floor(e*(100+t)/100)
    function automatic longint band_lo(logic [DUR_W-1:0] e);
        int t;
        t = cfg_m.tolerance;
        return longint'(e) * (PCT - t) / PCT;
    endfunction

    function automatic longint band_hi(logic [DUR_W-1:0] e);
        int t;
        t = cfg_m.tolerance;
        return longint'(e) * (PCT + t) / PCT;
    endfunction

    function automatic bit dur_near(logic [DUR_W-1:0] d, logic [DUR_W-1:0] e);
        return (longint'(d) >= band_lo(e)) && (longint'(d) <= band_hi(e));
    endfunction

    function automatic void note_err(logic [ERR_W-1:0] code);
        if (err_first == ERR_NONE)
            err_first = code;
    endfunction

    function automatic void clear_frame_state();
        ent_idx   = '0;
        bits_in   = '0;
        held_byte = '0;
        code_acc  = '0;
        err_first = ERR_NONE;
        rpt_flag  = 1'b0;
    endfunction

    // advance the decoder copy by one accepted duration beat
    function automatic void decode_duration(logic [DUR_W-1:0] d, logic last);
        int idx, rel, pos, byte_no;
        logic bad;
        logic [ERR_W-1:0] err;
        t_frame_res r;
        idx = ent_idx;
        bad = 1'b0;
        if (idx == ENT_LEAD) begin
            rpt_flag = dur_near(d, cfg_m.rpt_space);
        end else if (idx == ENT_HDR_MARK) begin
            if (!dur_near(d, cfg_m.hdr_mark))
                note_err(ERR_HDR_MARK);
        end else if (idx == ENT_HDR_SPC) begin
            if (!dur_near(d, cfg_m.hdr_space))
                note_err(ERR_HDR_SPACE);
        end else if (idx <= LAST_DATA) begin
            rel     = idx - FIRST_DATA;
            pos     = rel % BYTE_ENTRIES;
            byte_no = rel / BYTE_ENTRIES;
            if (pos % 2 == 0) begin
                bad = !dur_near(d, cfg_m.bit_mark);
            end else if (dur_near(d, cfg_m.one_space)) begin
                // a space inside both windows reads as a one
                bits_in = {bits_in[BYTE_W-2:0], 1'b1};
            end else if (dur_near(d, cfg_m.zero_space)) begin
                bits_in = {bits_in[BYTE_W-2:0], 1'b0};
            end else begin
                bad = 1'b1;
            end
            // bit timing overrides an earlier complement mismatch
            if (bad && (err_first == ERR_NONE || err_first == ERR_COMPL))
                err_first = ERR_BIT;
            if (pos == BYTE_ENTRIES - 1) begin
                if (byte_no % 2 == 0) begin
                    held_byte = bits_in;
                end else begin
                    if (~held_byte != bits_in)
                        note_err(ERR_COMPL);
                    code_acc = code_acc | (CODE_W'(held_byte) << (BYTE_W * (byte_no / 2)));
                end
                bits_in = '0;
            end
        end
        if (ent_idx != ENTRY_MAX)
            ent_idx = ent_idx + 1'b1;
        if (last) begin
            err    = (idx + 1 != FRAME_ENTRIES) ? ERR_COUNT : err_first;
            r.ok   = (err == ERR_NONE);
            r.err  = err;
            r.rpt  = rpt_flag;
            r.code = r.ok ? code_acc : '0;
            frame_results_due.push_back(r);
            clear_frame_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // frame building
    // ------------------------------------------------------------------------

    // a duration inside the window, now and then right on one of its edges
    function automatic logic [DUR_W-1:0] dur_within(logic [DUR_W-1:0] e);
        longint lo, hi;
        lo = band_lo(e);
        hi = band_hi(e);
        if (hi > DUR_MAX)
            hi = DUR_MAX;
        case ($urandom_range(9, 0))
            0:       return DUR_W'(lo);
            1:       return DUR_W'(hi);
            default: return DUR_W'($urandom_range(int'(hi), int'(lo)));
        endcase
    endfunction

    // the nearest duration just outside the window
    function automatic logic [DUR_W-1:0] dur_outside(logic [DUR_W-1:0] e);
        if (band_hi(e) < DUR_MAX)
            return DUR_W'(band_hi(e) + 1);
        else if (band_lo(e) > 0)
            return DUR_W'(band_lo(e) - 1);
        return DUR_W'(DUR_MAX);
    endfunction

    function automatic logic [DUR_W-1:0] rand_expected();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return DUR_W'(DUR_MAX);
            2:       return DUR_W'($urandom);
            default: return DUR_W'($urandom_range(9000, 200));
        endcase
    endfunction

    // well-formed frame under the current settings, flip spoils complement bits
    function automatic void build_frame(logic [CODE_W-1:0] code, logic [CODE_W-1:0] flip,
                                        logic rpt);
        logic [2*BYTE_W-1:0] pair_bits;
        int p, k;
        frame_q.delete();
        frame_q.push_back(rpt ? dur_within(cfg_m.rpt_space) : DUR_W'($urandom));
        frame_q.push_back(dur_within(cfg_m.hdr_mark));
        frame_q.push_back(dur_within(cfg_m.hdr_space));
        for (p = 0; p < PAIRS; p++) begin
            pair_bits = {code[BYTE_W*p +: BYTE_W],
                         ~code[BYTE_W*p +: BYTE_W] ^ flip[BYTE_W*p +: BYTE_W]};
            for (k = 2*BYTE_W-1; k >= 0; k--) begin
                frame_q.push_back(dur_within(cfg_m.bit_mark));
                frame_q.push_back(dur_within(pair_bits[k] ? cfg_m.one_space
                                                          : cfg_m.zero_space));
            end
        end
        // trailing mark, never looked at
        frame_q.push_back(dur_within(cfg_m.bit_mark));
    endfunction

    function automatic void trim_frame(int n);
        while (frame_q.size() > n)
            frame_q.delete(frame_q.size() - 1);
    endfunction

    // ------------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------------

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(MAX_WAIT, 0);
    endfunction

    // one duration beat; valid stays high afterwards so a zero gap is back to back
    task automatic send_beat(logic [DUR_W-1:0] d, logic last);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_duration_us <= d;
        i_frame_end   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_duration(d, last);
        beats_sent++;
    endtask

    task automatic send_frame();
        int n;
        for (n = 0; n < frame_q.size(); n++)
            send_beat(frame_q[n], n == frame_q.size() - 1);
        frames_sent++;
    endtask

    // sender holds off until every frame result is back and the pipe is empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HDR_MARK:   cfg_m.hdr_mark   = data;
            CFG_HDR_SPACE:  cfg_m.hdr_space  = data;
            CFG_BIT_MARK:   cfg_m.bit_mark   = data;
            CFG_ONE_SPACE:  cfg_m.one_space  = data;
            CFG_ZERO_SPACE: cfg_m.zero_space = data;
            CFG_RPT_SPACE:  cfg_m.rpt_space  = data;
            CFG_TOLERANCE:  cfg_m.tolerance  = data[TOL_W-1:0];
            default: ;
        endcase
    endtask

    // only called with the decoder idle; tol_pad fills the unused upper data bits
    task automatic apply_settings(t_cfg c, logic [6:0] which,
                                  logic [DUR_W-TOL_W-1:0] tol_pad);
        if (which[CFG_HDR_MARK])   write_reg(CFG_HDR_MARK, c.hdr_mark);
        if (which[CFG_HDR_SPACE])  write_reg(CFG_HDR_SPACE, c.hdr_space);
        if (which[CFG_BIT_MARK])   write_reg(CFG_BIT_MARK, c.bit_mark);
        if (which[CFG_ONE_SPACE])  write_reg(CFG_ONE_SPACE, c.one_space);
        if (which[CFG_ZERO_SPACE]) write_reg(CFG_ZERO_SPACE, c.zero_space);
        if (which[CFG_RPT_SPACE])  write_reg(CFG_RPT_SPACE, c.rpt_space);
        if (which[CFG_TOLERANCE])  write_reg(CFG_TOLERANCE, {tol_pad, c.tolerance});
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure and the field by field check
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (fault_count < 40)
            $display("MISMATCH result %0d %s: expected %0h, got %0h",
                     results_checked, what, want, got);
        fault_count++;
    endtask

    always @(posedge i_clk) begin
        t_frame_res due;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (frame_results_due.size() == 0) begin
                    flag_mismatch("beat with no frame outstanding", '0, o_code_value);
                end else begin
                    due = frame_results_due.pop_front();
                    if (o_frame_ok !== due.ok)
                        flag_mismatch("frame_ok", due.ok, o_frame_ok);
                    if (o_error_code !== due.err)
                        flag_mismatch("error_code", due.err, o_error_code);
                    if (o_is_repeat !== due.rpt)
                        flag_mismatch("is_repeat", due.rpt, o_is_repeat);
                    if (o_code_value !== due.code)
                        flag_mismatch("code_value", due.code, o_code_value);
                    if (due.ok)
                        clean_seen++;
                end
                results_checked++;
                rx_hold = draw_gap();
                i_ready <= (rx_hold == 0);
            end else if (rx_hold != 0) begin
                rx_hold--;
                if (rx_hold == 0)
                    i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d frame results still due",
                     cycle_count, frame_results_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values of every register in use: clean frames, repeat gap, trailing mark
    task automatic test_reset_defaults();
        build_frame('0, '0, 1'b0);
        send_frame();
        build_frame('1, '0, 1'b1);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b1);
        frame_q[FRAME_ENTRIES-1] = dur_outside(cfg_m.bit_mark);
        send_frame();
    endtask

    // wrong number of entries, including a run past the saturating counter
    task automatic test_entry_count();
        frame_q.delete();
        frame_q.push_back('0);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b0);
        trim_frame(FRAME_ENTRIES - 1);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b1);
        frame_q.push_back(dur_within(cfg_m.bit_mark));
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b0);
        repeat (30) frame_q.push_back(DUR_W'(DUR_MAX));
        send_frame();
        // count outranks a bad header mark
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[ENT_HDR_MARK] = dur_outside(cfg_m.hdr_mark);
        trim_frame(50);
        send_frame();
    endtask

    // header faults, run with no idling at all
    task automatic test_header_errors();
        steady_flow = 1'b1;
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[ENT_HDR_MARK] = dur_outside(cfg_m.hdr_mark);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b1);
        frame_q[ENT_HDR_SPC] = dur_outside(cfg_m.hdr_space);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[ENT_HDR_MARK] = '0;
        frame_q[ENT_HDR_SPC]  = DUR_W'(DUR_MAX);
        send_frame();
        steady_flow = 1'b0;
    endtask

    // bit timing and complement faults and how they rank
    task automatic test_bit_errors();
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[FIRST_DATA] = dur_outside(cfg_m.bit_mark);
        send_frame();
        // space fitting neither window
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[FIRST_DATA+1] = dur_outside(cfg_m.one_space);
        send_frame();
        build_frame(CODE_W'($urandom), 24'h000100, 1'b0);
        send_frame();
        // complement mismatch first, bit timing fault late in the frame
        build_frame(CODE_W'($urandom), 24'h000001, 1'b1);
        frame_q[LAST_DATA-9] = dur_outside(cfg_m.bit_mark);
        send_frame();
        // bit timing fault first, complement mismatch in the last pair
        build_frame(CODE_W'($urandom), 24'h800000, 1'b0);
        frame_q[FIRST_DATA] = '0;
        send_frame();
    endtask

    // every register written, the extremes of each and overlapping bit windows
    task automatic test_register_extremes();
        t_cfg c;
        int k;
        // widest tolerance: one and zero windows overlap
        wait_idle();
        c = RESET_CFG;
        c.tolerance = '1;
        apply_settings(c, ALL_REGS, '0);
        build_frame(CODE_W'($urandom), '0, 1'b1);
        send_frame();
        build_frame('0, '0, 1'b0);
        for (k = 0; k < BYTE_W; k++)
            frame_q[FIRST_DATA + 1 + 2*k] = DUR_W'(band_lo(cfg_m.one_space));
        send_frame();
        // exact match only
        wait_idle();
        c.hdr_mark   = rand_expected();
        c.hdr_space  = rand_expected();
        c.bit_mark   = DUR_W'($urandom_range(900, 300));
        c.one_space  = DUR_W'($urandom_range(2500, 1500));
        c.zero_space = DUR_W'($urandom_range(900, 300));
        c.rpt_space  = rand_expected();
        c.tolerance  = '0;
        apply_settings(c, ALL_REGS, '0);
        build_frame(CODE_W'($urandom), '0, 1'b1);
        send_frame();
        build_frame(CODE_W'($urandom), '0, 1'b0);
        frame_q[ENT_HDR_SPC] = cfg_m.hdr_space + 1'b1;
        send_frame();
        // all windows shrink to zero
        wait_idle();
        c = '0;
        apply_settings(c, ALL_REGS, '0);
        build_frame(CODE_W'($urandom), '0, 1'b1);
        send_frame();
        // all at the top, upper windows clipped by the duration width
        wait_idle();
        c = '{DUR_W'(DUR_MAX), DUR_W'(DUR_MAX), DUR_W'(DUR_MAX), DUR_W'(DUR_MAX),
              DUR_W'(DUR_MAX), DUR_W'(DUR_MAX), 6'd50};
        apply_settings(c, ALL_REGS, '0);
        build_frame(CODE_W'($urandom), '0, 1'b1);
        send_frame();
        wait_idle();
        apply_settings(RESET_CFG, ALL_REGS, '0);
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic test_random_traffic();
        t_cfg c;
        int pick, first_beat, phase_left, slot;
        logic [CODE_W-1:0] flip;
        first_beat  = beats_sent;
        phase_left  = 0;
        while (beats_sent - first_beat < RAND_BEATS)
        begin
            if (phase_left == 0) begin
                wait_idle();
                c.hdr_mark   = rand_expected();
                c.hdr_space  = rand_expected();
                c.bit_mark   = rand_expected();
                c.one_space  = rand_expected();
                c.zero_space = rand_expected();
                c.rpt_space  = rand_expected();
                case ($urandom_range(7, 0))
                    0:       c.tolerance = '0;
                    1:       c.tolerance = 6'd50;
                    2:       c.tolerance = '1;
                    default: c.tolerance = TOL_W'($urandom_range(50, 0));
                endcase
                if ($urandom_range(3, 0) == 0)
                    c = RESET_CFG;
                apply_settings(c, $urandom_range(1, 0) ? ALL_REGS : 7'($urandom),
                               $urandom_range(1, 0) ? (DUR_W-TOL_W)'($urandom) : '0);
                phase_left  = $urandom_range(10, 3);
                steady_flow = ($urandom_range(3, 0) == 0);
            end
            pick = $urandom_range(99, 0);
            flip = (pick >= 55 && pick < 65) ? (CODE_W'(1) << $urandom_range(23, 0)) : '0;
            if (pick >= 94) begin
                // short burst of raw noise
                frame_q.delete();
                repeat ($urandom_range(8, 1)) frame_q.push_back(DUR_W'($urandom));
            end else begin
                build_frame(CODE_W'($urandom), flip, $urandom_range(1, 0));
                if (pick >= 65 && pick < 75) begin
                    if ($urandom_range(1, 0)) begin
                        slot = $urandom_range(FRAME_ENTRIES - 1, 0);
                        frame_q[slot] = DUR_W'($urandom);
                    end else begin
                        slot = FIRST_DATA + 2 * $urandom_range(2*PAIRS*BYTE_W - 1, 0);
                        frame_q[slot] = dur_outside(cfg_m.bit_mark);
                    end
                end else if (pick >= 75 && pick < 82) begin
                    trim_frame($urandom_range(FRAME_ENTRIES - 1, 1));
                end else if (pick >= 82 && pick < 88) begin
                    repeat ($urandom_range(40, 1)) frame_q.push_back(DUR_W'($urandom));
                end else if (pick >= 88) begin
                    if ($urandom_range(1, 0))
                        frame_q[ENT_HDR_MARK] = dur_outside(cfg_m.hdr_mark);
                    else
                        frame_q[ENT_HDR_SPC] = dur_outside(cfg_m.hdr_space);
                end
            end
            send_frame();
            phase_left--;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_entry_count();
        test_header_errors();
        test_bit_errors();
        test_register_extremes();
        test_random_traffic();

        // drain, then allow the pipe to settle so stray beats get caught
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d frames in %0d duration beats across %0d register settings",
                 frames_sent, beats_sent, settings_used);
        $display("checked %0d results, %0d of them clean decodes, %0d mismatches",
                 results_checked, clean_seen, fault_count);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
